[rtl/core/cdq_pkg.sv]
package cdq_pkg;

	localparam int VAL_W = 32;

	localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
	localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
	localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
	localparam logic [1:0] CMD_POP_BACK   = 2'd3;

	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic take;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_valid;
		logic pop_ok;
	} dp_status_t;

endpackage

[rtl/core/cdq_ctrl.sv]
module cdq_ctrl
	import cdq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic       m_tready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	logic state_q;
	logic state_d;

	assign s_tready   = (state_q == ST_IDLE) && (!status.out_valid || m_tready);
	assign cmd.take   = s_tvalid && s_tready;
	assign cmd.finish = (state_q == ST_READ);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.take && status.pop_ok) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/core/cdq_datapath.sv]
module cdq_datapath
	import cdq_pkg::*;
#(
	parameter int DEPTH      = 8,
	parameter int DATA_WIDTH = 32,
	parameter int IDX_W      = 3,
	parameter int CNT_W      = 4,
	parameter int OUT_W      = 40
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [VAL_W-1:0]   s_tdata,
	input  logic [1:0]         s_tuser,
	input  logic               m_tready,
	output logic               m_tvalid,
	output logic [OUT_W-1:0]   m_tdata,
	output logic [1:0]         m_tuser,
	input  ctrl_cmd_t          cmd,
	output dp_status_t         status
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;

	logic             out_valid_q;
	logic [1:0]       stat_q;
	logic [VAL_W-1:0] popped_q;
	logic [CNT_W-1:0] fill_q;

	logic             is_push;
	logic             is_front;
	logic             empty;
	logic             full;
	logic             push_ok;
	logic             pop_ok;
	logic [IDX_W-1:0] head_prev;
	logic [IDX_W-1:0] head_next;
	logic [IDX_W-1:0] tail_prev;
	logic [IDX_W-1:0] tail_next;
	logic [IDX_W-1:0] head_d;
	logic [IDX_W-1:0] tail_d;
	logic [CNT_W-1:0] count_d;
	logic [IDX_W-1:0] wslot;
	logic [IDX_W-1:0] rslot;
	logic [1:0]       stat_d;

	logic [DATA_WIDTH+VAL_W-1:0] wext;
	logic [DATA_WIDTH+VAL_W-1:0] rext;

	assign is_push  = (s_tuser == CMD_PUSH_FRONT) || (s_tuser == CMD_PUSH_BACK);
	assign is_front = (s_tuser == CMD_PUSH_FRONT) || (s_tuser == CMD_POP_FRONT);
	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign push_ok  = is_push && !full;
	assign pop_ok   = !is_push && !empty;

	assign head_prev = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - 1'b1;
	assign head_next = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_prev = (tail_q == '0) ? IDX_W'(DEPTH - 1) : tail_q - 1'b1;
	assign tail_next = (tail_q == IDX_W'(DEPTH - 1)) ? '0 : tail_q + 1'b1;

	assign wext = {{DATA_WIDTH{1'b0}}, s_tdata};
	assign rext = {{VAL_W{1'b0}}, rdata_q};

	always_comb begin
		head_d  = head_q;
		tail_d  = tail_q;
		count_d = count_q;
		wslot   = '0;
		rslot   = is_front ? head_q : tail_q;
		stat_d  = STAT_DONE;
		if (is_push) begin
			if (full) begin
				stat_d = STAT_FULL;
			end else begin
				count_d = count_q + 1'b1;
				if (empty) begin
					head_d = '0;
					tail_d = '0;
					wslot  = '0;
				end else if (is_front) begin
					head_d = head_prev;
					wslot  = head_prev;
				end else begin
					tail_d = tail_next;
					wslot  = tail_next;
				end
			end
		end else begin
			if (empty) begin
				stat_d = STAT_EMPTY;
			end else begin
				count_d = count_q - 1'b1;
				if (count_q == CNT_W'(1)) begin
					head_d = '0;
					tail_d = '0;
				end else if (is_front) begin
					head_d = head_next;
				end else begin
					tail_d = tail_prev;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && push_ok) begin
			mem[wslot] <= wext[DATA_WIDTH-1:0];
		end
		if (cmd.take && pop_ok) begin
			rdata_q <= mem[rslot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (cmd.take) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.take && !pop_ok) || cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			stat_q   <= stat_d;
			popped_q <= '0;
			fill_q   <= count_d;
		end else if (cmd.finish) begin
			popped_q <= rext[VAL_W-1:0];
		end
	end

	assign m_tvalid         = out_valid_q;
	assign m_tuser          = stat_q;
	assign m_tdata          = OUT_W'({fill_q, popped_q});
	assign status.out_valid = out_valid_q;
	assign status.pop_ok    = pop_ok;

endmodule

[rtl/core/circular_deque_unit.sv]
// Latency: a push or a refused command gives its result word in the cycle after acceptance;
// a successful pop first reads the store into its registered read port, then gives it.
// Throughput: one push per cycle unless output stalls; a pop blocks input while it reads.
// Reset: arst_n clears head, tail, fill count, controller state and output valid;
// store contents stay undefined until written.
module circular_deque_unit
	import cdq_pkg::*;
#(
	parameter int DEPTH      = 8,
	parameter int DATA_WIDTH = 32,
	localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W     = $clog2(DEPTH + 1),
	localparam int OUT_W     = ((VAL_W + CNT_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [VAL_W-1:0] s_tdata,  // push_value
	input  logic [1:0]       s_tuser,  // command
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,  // popped_value, fill_level, zero fill
	output logic [1:0]       m_tuser   // status
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	cdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	cdq_datapath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.IDX_W      (IDX_W),
		.CNT_W      (CNT_W),
		.OUT_W      (OUT_W)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cmd      (cmd),
		.status   (status)
	);

endmodule
